### sv/tcsg_pkg.sv
// shared types and constants for the thick circle span generator
`timescale 1ns / 1ps
`default_nettype none

package tcsg_pkg;

    localparam int CoordInBits  = 11;
    localparam int RadiusBits   = 10;
    localparam int WidthBits    = 8;
    localparam int ColorBits    = 32;
    localparam int RingBits     = 12;
    localparam int ErrBits      = 14;
    localparam int StepBits     = 11;
    localparam int SpanBits     = 13;
    localparam int InDataBits   = 72;
    localparam int OutDataBits  = 88;

    typedef enum logic
    {
        REQ_START   = 1'b0,
        REQ_ADVANCE = 1'b1
    } req_t;

    // span order within one step, one per octant
    localparam logic [2:0] OCT_1 = 3'd0;
    localparam logic [2:0] OCT_2 = 3'd1;
    localparam logic [2:0] OCT_3 = 3'd2;
    localparam logic [2:0] OCT_4 = 3'd3;
    localparam logic [2:0] OCT_5 = 3'd4;
    localparam logic [2:0] OCT_6 = 3'd5;
    localparam logic [2:0] OCT_7 = 3'd6;
    localparam logic [2:0] OCT_8 = 3'd7;

    // ring walker state, signed fields held as plain bits
    typedef struct packed
    {
        logic                   active;
        logic [CoordInBits-1:0] center_x;
        logic [CoordInBits-1:0] center_y;
        logic [RingBits-1:0]    inner_limit;
        logic [RingBits-1:0]    outer_x;
        logic [RingBits-1:0]    inner_x;
        logic [StepBits-1:0]    step_y;
        logic [ErrBits-1:0]     outer_err;
        logic [ErrBits-1:0]     inner_err;
        logic [ColorBits-1:0]   color;
    } ring_state_t;

    // everything needed to emit the eight spans of one step
    typedef struct packed
    {
        logic [CoordInBits-1:0] center_x;
        logic [CoordInBits-1:0] center_y;
        logic [RingBits-1:0]    outer_x;
        logic [RingBits-1:0]    inner_x;
        logic [StepBits-1:0]    step_y;
        logic [ColorBits-1:0]   color;
        logic                   done;
    } step_rec_t;

endpackage

`default_nettype wire

### sv/thick_circle_span_generator.sv
// top level of the thick ring span generator: step control and span output
//
// usage
//   s_axis: one request beat per step; tuser selects start (0) or advance (1),
//   tdata carries center, radius, ring width and color (used on start only)
//   m_axis: eight span beats per step, one per octant; tlast marks the
//   eighth span of a step, tuser marks the eighth span of the final step
// each step is computed in its accept cycle and registered into the span buffer,
//   or into the holding slot while that buffer is busy; spans go out one per cycle while m_axis_tready
// a new request can be taken while the spans of an earlier step still go out
// an advance with no ring running is taken and produces no span
// a start while a ring runs drops the old ring; spans already computed
//   still go out in full
// stall: a computed step waits in a one-step holding slot behind the span
//   buffer; s_axis_tready drops only while that slot is full
// reset: rst_n clears the walker to idle and empties both step slots
`timescale 1ns / 1ps
`default_nettype none

module thick_circle_span_generator #(
    parameter int COORD_BITS = 11,
    parameter int MAX_RADIUS = 1023,
    parameter int MAX_WIDTH  = 255
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    // request beats
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    // center_x[10:0], center_y[21:11], radius[31:22], ring_width[39:32],
    // color[71:40]
    input  wire [tcsg_pkg::InDataBits-1:0]       s_axis_tdata,
    // req_type[0]
    input  wire [0:0]                            s_axis_tuser,
    // span beats
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // span_x0[12:0], span_y0[25:13], span_x1[38:26], span_y1[51:39],
    // span_color[83:52], zero pad[87:84]
    output logic [tcsg_pkg::OutDataBits-1:0]     m_axis_tdata,
    // last_of_step
    output logic                                 m_axis_tlast,
    // circle_done[0]
    output logic [0:0]                           m_axis_tuser
);
    import tcsg_pkg::*;

    ring_state_t state_reg;
    ring_state_t state_next;
    step_rec_t   step_rec;
    logic        step_emit;

    // holding slot and span buffer, each one full step
    step_rec_t   pend_reg;
    logic        pend_valid_reg;
    step_rec_t   buf_reg;
    logic        buf_valid_reg;
    logic [2:0]  idx_reg;

    logic        in_beat;
    logic        is_start;
    logic        load;
    logic        out_beat;
    logic        step_end;
    logic        buf_free;

    logic [SpanBits-1:0] x0;
    logic [SpanBits-1:0] y0;
    logic [SpanBits-1:0] x1;
    logic [SpanBits-1:0] y1;

    assign s_axis_tready = ~pend_valid_reg;
    assign in_beat       = s_axis_tvalid & s_axis_tready;
    assign is_start      = (s_axis_tuser[0] == REQ_START);
    assign load          = in_beat & step_emit;

    assign m_axis_tvalid = buf_valid_reg;
    assign out_beat      = m_axis_tvalid & m_axis_tready;
    assign step_end      = out_beat & (idx_reg == OCT_8);
    assign buf_free      = ~buf_valid_reg | step_end;

    tcsg_step #(
        .COORD_BITS (COORD_BITS),
        .MAX_RADIUS (MAX_RADIUS),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_step (
        .cur        (state_reg),
        .start      (is_start),
        .center_x   (s_axis_tdata[10:0]),
        .center_y   (s_axis_tdata[21:11]),
        .radius     (s_axis_tdata[31:22]),
        .ring_width (s_axis_tdata[39:32]),
        .color      (s_axis_tdata[71:40]),
        .emit       (step_emit),
        .nxt        (state_next),
        .rec        (step_rec)
    );

    tcsg_span_sel u_span_sel (
        .rec (buf_reg),
        .idx (idx_reg),
        .x0  (x0),
        .y0  (y0),
        .x1  (x1),
        .y1  (y1)
    );

    // walker state loads state_next on every accepted request; an idle advance leaves it unchanged
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (in_beat)
        begin
            state_reg <= state_next;
        end
    end

    // step slot control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            buf_valid_reg  <= 1'b0;
            idx_reg        <= OCT_1;
        end
        else
        begin
            if (out_beat)
            begin
                idx_reg <= idx_reg + 3'd1;
            end
            if (buf_free)
            begin
                if (pend_valid_reg)
                begin
                    buf_valid_reg  <= 1'b1;
                    pend_valid_reg <= load;
                end
                else
                begin
                    buf_valid_reg <= load;
                end
            end
            else if (load)
            begin
                pend_valid_reg <= 1'b1;
            end
        end
    end

    // step payloads
    always_ff @(posedge clk)
    begin
        if (buf_free)
        begin
            if (pend_valid_reg)
            begin
                buf_reg <= pend_reg;
                if (load)
                begin
                    pend_reg <= step_rec;
                end
            end
            else if (load)
            begin
                buf_reg <= step_rec;
            end
        end
        else if (load)
        begin
            pend_reg <= step_rec;
        end
    end

    assign m_axis_tdata = {4'b0000, buf_reg.color, y1, x1, y0, x0};
    assign m_axis_tlast = (idx_reg == OCT_8);
    assign m_axis_tuser = buf_reg.done & (idx_reg == OCT_8);

    // a held step always has a step ahead of it in the span buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> buf_valid_reg)
    else $error("holding slot full while span buffer empty");

    // a step stays in the buffer until its eighth span has gone
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_beat && idx_reg != OCT_8) |=> buf_valid_reg)
    else $error("span buffer emptied in mid step");

    // an advance with no ring running leaves the walker untouched
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && !is_start && !state_reg.active) |=> $stable(state_reg))
    else $error("idle advance changed walker state");

    // each running advance moves the row offset by exactly one
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && !is_start && state_reg.active)
        |=> (state_reg.step_y == $past(state_reg.step_y) + 11'd1))
    else $error("row offset did not step by one");

    // a held step stays in the holding slot while the span buffer is busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (pend_valid_reg && !buf_free) |=> pend_valid_reg)
    else $error("held step lost while span buffer busy");

endmodule

`default_nettype wire

### sv/tcsg_step.sv
// one midpoint step of the outer and inner ring edges, with start loading
`timescale 1ns / 1ps
`default_nettype none

module tcsg_step #(
    parameter int COORD_BITS = 11,
    parameter int MAX_RADIUS = 1023,
    parameter int MAX_WIDTH  = 255
) (
    input  wire tcsg_pkg::ring_state_t                 cur,
    input  wire                                        start,
    input  wire [tcsg_pkg::CoordInBits-1:0]            center_x,
    input  wire [tcsg_pkg::CoordInBits-1:0]            center_y,
    input  wire [tcsg_pkg::RadiusBits-1:0]             radius,
    input  wire [tcsg_pkg::WidthBits-1:0]              ring_width,
    input  wire [tcsg_pkg::ColorBits-1:0]              color,
    output logic                                       emit,
    output tcsg_pkg::ring_state_t                      nxt,
    output tcsg_pkg::step_rec_t                        rec
);
    import tcsg_pkg::*;

    localparam logic [CoordInBits-1:0] CenterMask = CoordInBits'((64'd1 << COORD_BITS) - 64'd1);

    logic [RadiusBits-1:0]      r_sat;
    logic [WidthBits-1:0]       w_sat;
    logic [WidthBits-2:0]       half;
    logic signed [RingBits-1:0] r_s;
    logic signed [RingBits-1:0] half_s;
    logic signed [RingBits-1:0] xo_ld;
    logic signed [RingBits-1:0] xi_ld;
    logic signed [RingBits-1:0] lim_ld;
    ring_state_t                base;

    logic [StepBits-1:0]        ny;
    logic signed [ErrBits-1:0]  ny_e;
    logic signed [ErrBits-1:0]  odd_e;
    logic signed [ErrBits-1:0]  eo;
    logic signed [ErrBits-1:0]  ei;
    logic signed [RingBits-1:0] xo;
    logic signed [RingBits-1:0] xi;
    logic signed [RingBits-1:0] lim;
    logic signed [RingBits-1:0] xo_n;
    logic signed [RingBits-1:0] xi_n;
    logic signed [ErrBits-1:0]  eo_n;
    logic signed [ErrBits-1:0]  ei_n;
    logic signed [ErrBits-1:0]  d_o;
    logic signed [ErrBits-1:0]  d_i;
    logic signed [RingBits:0]   ny_c;
    logic                       done;

    always_comb
    begin
        // operand saturation
        r_sat  = (32'(radius) > MAX_RADIUS) ? RadiusBits'(MAX_RADIUS) : radius;
        w_sat  = (32'(ring_width) > MAX_WIDTH) ? WidthBits'(MAX_WIDTH) : ring_width;
        half   = w_sat[WidthBits-1:1];
        r_s    = $signed({2'b00, r_sat});
        half_s = $signed({5'b00000, half});
        xo_ld  = r_s + half_s;
        xi_ld  = r_s - half_s - 12'sd1;
        lim_ld = r_s - half_s;

        base = cur;
        if (start)
        begin
            base.active      = 1'b1;
            base.center_x    = center_x & CenterMask;
            base.center_y    = center_y & CenterMask;
            base.color       = color;
            base.outer_x     = xo_ld;
            base.inner_x     = xi_ld;
            base.inner_limit = lim_ld;
            base.step_y      = '0;
            base.outer_err   = 14'sd1 - {{2{xo_ld[RingBits-1]}}, xo_ld};
            base.inner_err   = 14'sd1 - {{2{xi_ld[RingBits-1]}}, xi_ld};
        end
        emit = start | cur.active;

        xo  = $signed(base.outer_x);
        xi  = $signed(base.inner_x);
        lim = $signed(base.inner_limit);
        eo  = $signed(base.outer_err);
        ei  = $signed(base.inner_err);

        ny    = base.step_y + 11'd1;
        ny_e  = $signed({3'b000, ny});
        odd_e = $signed({2'b00, ny, 1'b1});
        ny_c  = $signed({2'b00, ny});

        // outer edge
        xo_n = xo;
        d_o  = '0;
        if (eo < 0)
        begin
            eo_n = eo + odd_e;
        end
        else
        begin
            xo_n = xo - 12'sd1;
            d_o  = ny_e - {{2{xo_n[RingBits-1]}}, xo_n} + 14'sd1;
            eo_n = eo + {d_o[ErrBits-2:0], 1'b0};
        end

        // inner edge follows y once past its limit
        xi_n = xi;
        ei_n = ei;
        d_i  = '0;
        if (ny_c > $signed({lim[RingBits-1], lim}))
        begin
            xi_n = $signed({1'b0, ny});
        end
        else if (ei < 0)
        begin
            ei_n = ei + odd_e;
        end
        else
        begin
            xi_n = xi - 12'sd1;
            d_i  = ny_e - {{2{xi_n[RingBits-1]}}, xi_n} + 14'sd1;
            ei_n = ei + {d_i[ErrBits-2:0], 1'b0};
        end

        done = $signed({xo_n[RingBits-1], xo_n}) < ny_c;

        rec.center_x = base.center_x;
        rec.center_y = base.center_y;
        rec.outer_x  = base.outer_x;
        rec.inner_x  = base.inner_x;
        rec.step_y   = base.step_y;
        rec.color    = base.color;
        rec.done     = done;

        nxt = cur;
        if (emit)
        begin
            nxt           = base;
            nxt.active    = ~done;
            nxt.step_y    = ny;
            nxt.outer_x   = xo_n;
            nxt.inner_x   = xi_n;
            nxt.outer_err = eo_n;
            nxt.inner_err = ei_n;
        end
    end

endmodule

`default_nettype wire

### sv/tcsg_span_sel.sv
// endpoint selection for one of the eight octant spans of a step
`timescale 1ns / 1ps
`default_nettype none

module tcsg_span_sel (
    input  wire tcsg_pkg::step_rec_t            rec,
    input  wire [2:0]                           idx,
    output logic [tcsg_pkg::SpanBits-1:0]       x0,
    output logic [tcsg_pkg::SpanBits-1:0]       y0,
    output logic [tcsg_pkg::SpanBits-1:0]       x1,
    output logic [tcsg_pkg::SpanBits-1:0]       y1
);
    import tcsg_pkg::*;

    logic [SpanBits-1:0] cx;
    logic [SpanBits-1:0] cy;
    logic [SpanBits-1:0] xo;
    logic [SpanBits-1:0] xi;
    logic [SpanBits-1:0] yy;
    logic [SpanBits-1:0] cx_pi;
    logic [SpanBits-1:0] cx_po;
    logic [SpanBits-1:0] cx_mi;
    logic [SpanBits-1:0] cx_mo;
    logic [SpanBits-1:0] cx_py;
    logic [SpanBits-1:0] cx_my;
    logic [SpanBits-1:0] cy_pi;
    logic [SpanBits-1:0] cy_po;
    logic [SpanBits-1:0] cy_mi;
    logic [SpanBits-1:0] cy_mo;
    logic [SpanBits-1:0] cy_py;
    logic [SpanBits-1:0] cy_my;

    always_comb
    begin
        cx = {2'b00, rec.center_x};
        cy = {2'b00, rec.center_y};
        xo = {rec.outer_x[RingBits-1], rec.outer_x};
        xi = {rec.inner_x[RingBits-1], rec.inner_x};
        yy = {2'b00, rec.step_y};

        cx_pi = cx + xi;
        cx_po = cx + xo;
        cx_mi = cx - xi;
        cx_mo = cx - xo;
        cx_py = cx + yy;
        cx_my = cx - yy;
        cy_pi = cy + xi;
        cy_po = cy + xo;
        cy_mi = cy - xi;
        cy_mo = cy - xo;
        cy_py = cy + yy;
        cy_my = cy - yy;

        unique case (idx)
            OCT_1:   begin x0 = cx_pi; y0 = cy_py; x1 = cx_po; y1 = cy_py; end
            OCT_2:   begin x0 = cx_py; y0 = cy_pi; x1 = cx_py; y1 = cy_po; end
            OCT_3:   begin x0 = cx_mo; y0 = cy_py; x1 = cx_mi; y1 = cy_py; end
            OCT_4:   begin x0 = cx_my; y0 = cy_pi; x1 = cx_my; y1 = cy_po; end
            OCT_5:   begin x0 = cx_mo; y0 = cy_my; x1 = cx_mi; y1 = cy_my; end
            OCT_6:   begin x0 = cx_my; y0 = cy_mo; x1 = cx_my; y1 = cy_mi; end
            OCT_7:   begin x0 = cx_pi; y0 = cy_my; x1 = cx_po; y1 = cy_my; end
            default: begin x0 = cx_py; y0 = cy_mo; x1 = cx_py; y1 = cy_mi; end
        endcase
    end

endmodule

`default_nettype wire
